### rtl/u2j_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2j_pkg;

  // default depth of the job queue between decoder and emitter
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CP_W      = 21;
  localparam int PAYLOAD_W = 20;

  // job kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;  // one character as is
  localparam logic [1:0] KIND_ESC2 = 2'd1;  // backslash + one character
  localparam logic [1:0] KIND_HEX4 = 2'd2;  // \uXXXX
  localparam logic [1:0] KIND_PAIR = 2'd3;  // surrogate pair, payload = cp - 0x10000

  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_U      = 7'h75;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] payload;
  } job_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'd0, nib};
    if (nib < 4'd10) begin
      return 7'h30 + n7;
    end else begin
      return 7'h57 + n7;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/utf8_to_json_escape_stream.sv
// A byte that completes a code point is pushed into the job queue; the emitter then
//   registers the first character of its job into the output register.
// Throughput: one byte per cycle in, one character per cycle out, each unless stalled;
//   a code point yields 1 to 12 characters, so the emitter paces the input via the queue.
// Input stalls only while the job queue (QUEUE_DEPTH entries) is full.
// Reset (rst, synchronous, active high) clears the decoder state, the queue and
//   the output valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_json_escape_stream import u2j_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte side
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] in_byte,
  // character side
  output logic            char_valid,
  input  wire logic       char_stall,
  output logic [6:0]      out_char,
  output logic            last_of_run
);

  logic accept;
  logic push;
  job_t push_job;
  job_t head;
  logic head_valid;
  logic pop;
  logic full;

  // stall comes straight from the queue's full flag (a register compare)
  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  // front: UTF-8 gathering and classification into escape jobs
  u2j_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push),
    .job     (push_job)
  );

  // job queue decouples decoder and emitter
  u2j_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .nonempty (head_valid),
    .full     (full)
  );

  // back: one character per cycle unless the output is stalled, the head job is popped with its last character
  u2j_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### rtl/u2j_front.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 decoder: gathers code points and classifies each into a job.
module u2j_front import u2j_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output job_t            job
);

  logic [CP_W-1:0] partial, partial_next;
  logic [1:0]      due, due_next;
  logic [CP_W-1:0] cp, cp_cont, cp_sup;
  logic            cont, done;

  always_comb begin
    cont    = (due != 2'd0);
    cp_cont = {partial[CP_W-7:0], in_byte[5:0]};
    cp      = cont ? cp_cont : {13'd0, in_byte};
    done    = cont ? (due == 2'd1) : (in_byte <= 8'h7F);
    cp_sup  = cp - 21'h10000;

    partial_next = partial;
    due_next     = due;
    if (cont) begin
      partial_next = cp_cont;
      due_next     = due - 2'd1;
    end else if (in_byte <= 8'h7F) begin
      partial_next = cp;
    end else if (in_byte >= 8'hC0 && in_byte <= 8'hDF) begin
      partial_next = {16'd0, in_byte[4:0]};
      due_next     = 2'd1;
    end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
      partial_next = {17'd0, in_byte[3:0]};
      due_next     = 2'd2;
    end else if (in_byte >= 8'hF0 && in_byte <= 8'hF7) begin
      partial_next = {18'd0, in_byte[2:0]};
      due_next     = 2'd3;
    end

    job.kind    = KIND_HEX4;
    job.payload = {4'd0, cp[15:0]};
    if (cp <= 21'h7F) begin
      job.kind    = KIND_ESC2;
      case (cp[6:0])
        7'h0A:   job.payload = {13'd0, 7'h6E};  // n
        7'h0D:   job.payload = {13'd0, 7'h72};  // r
        7'h0C:   job.payload = {13'd0, 7'h66};  // f
        7'h08:   job.payload = {13'd0, 7'h62};  // b
        7'h2F:   job.payload = {13'd0, 7'h2F};
        7'h22:   job.payload = {13'd0, 7'h22};
        7'h5C:   job.payload = {13'd0, CH_BSLASH};
        default: begin
          if (cp[6:0] inside {[7'h20:7'h7E]}) begin
            job.kind    = KIND_CHAR;
            job.payload = {13'd0, cp[6:0]};
          end else begin
            job.kind    = KIND_HEX4;
            job.payload = {4'd0, cp[15:0]};
          end
        end
      endcase
    end else if (cp > 21'hFFFF) begin
      job.kind    = KIND_PAIR;
      job.payload = cp_sup[PAYLOAD_W-1:0];
    end

    // values past 0x10FFFF are dropped
    push = accept && done && (cp <= 21'h10FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      due     <= 2'd0;
    end else if (accept) begin
      partial <= partial_next;
      due     <= due_next;
    end
  end

endmodule

`default_nettype wire

### rtl/u2j_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small job FIFO; head is visible without a read cycle.
module u2j_queue import u2j_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      nonempty,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head     = slots[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/u2j_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Emitter: walks the head job one character per cycle, unless the output is stalled, into the output register.
module u2j_back import u2j_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  job_t            head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            char_valid,
  input  wire logic       char_stall,
  output logic [6:0]      out_char,
  output logic            last_of_run
);

  logic [3:0]  pos;
  logic        hi_half, last, advance;
  logic [2:0]  sub;
  logic [15:0] word;
  logic [6:0]  ch, hex_ch;

  always_comb begin
    hi_half = (pos < 4'd6);
    sub     = hi_half ? pos[2:0] : 3'(pos - 4'd6);
    if (head.kind == KIND_PAIR) begin
      word = hi_half ? {6'b110110, head.payload[19:10]} : {6'b110111, head.payload[9:0]};
    end else begin
      word = head.payload[15:0];
    end

    case (sub)
      3'd0:    hex_ch = CH_BSLASH;
      3'd1:    hex_ch = CH_U;
      3'd2:    hex_ch = hex_char(word[15:12]);
      3'd3:    hex_ch = hex_char(word[11:8]);
      3'd4:    hex_ch = hex_char(word[7:4]);
      3'd5:    hex_ch = hex_char(word[3:0]);
      default: hex_ch = CH_BSLASH;
    endcase

    case (head.kind)
      KIND_CHAR: begin
        ch   = head.payload[6:0];
        last = 1'b1;
      end
      KIND_ESC2: begin
        ch   = (pos == 4'd0) ? CH_BSLASH : head.payload[6:0];
        last = (pos == 4'd1);
      end
      KIND_HEX4: begin
        ch   = hex_ch;
        last = (pos == 4'd5);
      end
      KIND_PAIR: begin
        ch   = hex_ch;
        last = (pos == 4'd11);
      end
      default: begin
        ch   = head.payload[6:0];
        last = 1'b1;
      end
    endcase

    advance = !char_valid || !char_stall;
    pop     = advance && head_valid && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      pos        <= 4'd0;
    end else if (advance) begin
      char_valid <= head_valid;
      if (head_valid) begin
        pos <= last ? 4'd0 : pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_char    <= ch;
      last_of_run <= last;
    end
  end

endmodule

`default_nettype wire

### rtl/u2j_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u2j_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_valid,
  input wire logic       byte_stall,
  input wire logic       char_valid,
  input wire logic       char_stall,
  input wire logic [6:0] out_char,
  input wire logic       last_of_run
);

  // after reset nothing is pending and the queue has room
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !char_valid && !byte_stall)
    else $error("output valid or input stall right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last_of_run))
    else $error("stalled output word changed");

  // any non-final character belongs to an escape: backslash, u or a hex digit
  a_mid_run_char: assert property (@(posedge clk) disable iff (rst)
    char_valid && !last_of_run |->
      (out_char == 7'h5C || out_char == 7'h75 ||
       (out_char >= 7'h30 && out_char <= 7'h39) ||
       (out_char >= 7'h61 && out_char <= 7'h66)))
    else $error("unexpected character inside an escape run");

  // the queue can not go from empty-ish to full while nothing was accepted
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(byte_valid && !byte_stall) && !$past(rst) |-> !$rose(byte_stall))
    else $error("input stall rose without an accepted word");

endmodule

bind utf8_to_json_escape_stream u2j_checker u_chk (.*);

`default_nettype wire
